/* rtl/mwq_pkg.sv */
package mwq_pkg;

	// Request codes.
	localparam logic [3:0] REQ_INSERT   = 4'd0;
	localparam logic [3:0] REQ_REINSERT = 4'd1;
	localparam logic [3:0] REQ_POP      = 4'd2;
	localparam logic [3:0] REQ_REMOVE   = 4'd3;
	localparam logic [3:0] REQ_CLEAR    = 4'd4;
	localparam logic [3:0] REQ_ZERO_CNT = 4'd5;
	localparam logic [3:0] REQ_INC_CNT  = 4'd6;
	localparam logic [3:0] REQ_WR_WGT   = 4'd7;
	localparam logic [3:0] REQ_WR_PAR   = 4'd8;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Inserted counts saturate here.
	localparam logic [6:0] INS_CNT_MAX = 7'h7F;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [5:0]  vertex;
		logic [5:0]  depth;
		logic [2:0]  slot;
		logic [30:0] weight;
		logic [6:0]  parent_count;
		logic [6:0]  vertex_count;
	} req_t;

	typedef struct packed {
		logic [5:0] popped_vertex;
		logic [1:0] status;
		logic [6:0] queue_count;
	} rsp_t;

	// Control from the scan sequencer to the minimum tracker.
	typedef struct packed {
		logic clear;
		logic take;
		logic first;
		logic elig;
	} scan_ctl_t;

endpackage

/* rtl/mwq_min_track.sv */
module mwq_min_track #(
	parameter int PW = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mwq_pkg::scan_ctl_t  ctl,
	input  logic [PW-1:0]       pos,
	input  logic [5:0]          vtx,
	input  logic [30:0]         wgt,
	output logic [PW-1:0]       best_pos,
	output logic [5:0]          best_vtx
);
	import mwq_pkg::*;

	logic        found_q;
	logic [30:0] best_wgt_q;
	logic [PW-1:0] best_pos_q;
	logic [5:0]  best_vtx_q;
	logic        better;

	// Strict less-than keeps the first position among equal weights.
	assign better = ctl.take && ctl.elig && (!found_q || (wgt < best_wgt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better || (ctl.take && ctl.first && !found_q)) begin
			best_pos_q <= pos;
			best_vtx_q <= vtx;
		end
		if (better) begin
			best_wgt_q <= wgt;
		end
	end

	assign best_pos = best_pos_q;
	assign best_vtx = best_vtx_q;

endmodule

/* rtl/min_weight_extendable_queue_unit.sv */
// Unordered queue of query vertices for a backtracking subgraph search, with a pop that
// takes the eligible vertex of least weight (first position on ties, position 0 when none
// is eligible). One request word is taken at a time and gives exactly one response word.
// For a pop, a sequencer streams the queue memory one entry a cycle through a parent-count
// lookup and a weight-table lookup into one shared compare unit, then moves the tail entry
// into the hole before the response word is issued. The next request is taken only after
// its predecessor's response word is issued. A response word waiting on a stalled output
// does not hold the next request out until that request has its own response ready. There
// is no clearing pass after reset.
module min_weight_extendable_queue_unit #(
	parameter int MAX_VERTICES = 64,
	parameter int DEGREE_LIMIT = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mwq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mwq_pkg::rsp_t  rsp
);
	import mwq_pkg::*;

	localparam int IW  = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int WD  = MAX_VERTICES * DEGREE_LIMIT;
	localparam int WAW = $clog2(WD);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_RI1  = 3'd3;
	localparam logic [2:0] S_RI2  = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;
	localparam logic [2:0] S_TAIL = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0]    state_q;
	logic [2:0]    pop_step_q;
	req_t          req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [1:0]    status_q;
	logic [5:0]    popped_q;
	logic [IW-1:0] pos_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// Memories.
	logic [5:0]  qe_mem [MAX_VERTICES];
	logic [5:0]  pp_mem [MAX_VERTICES];
	logic [6:0]  ic_mem [MAX_VERTICES];
	logic [6:0]  mp_mem [MAX_VERTICES];
	logic [30:0] wt_mem [WD];
	logic        ic_vld_q [MAX_VERTICES];
	logic        mp_vld_q [MAX_VERTICES];

	logic [5:0]  qe_rd_q;
	logic [5:0]  pp_rd_q;
	logic [6:0]  ic_rd_q;
	logic [6:0]  mp_rd_q;
	logic [30:0] wt_rd_q;

	// Scan pipeline.
	logic          v_s1, v_s2, v_s3;
	logic [IW-1:0] pos_s1, pos_s2, pos_s3;
	logic [5:0]    u_s2, u_s3;
	logic          ok_s2, mpv_s2, elig_s3;

	logic          accept;
	logic          dep_ok;
	logic [IW-1:0] dep_idx;
	logic          full;
	logic          issue;
	logic          scan_done;
	logic [IW-1:0] last_pos;
	logic [IW-1:0] ri_pos;
	logic [6:0]    np;
	logic          elig;
	logic [WAW-1:0] wt_raddr;
	logic [6:0]    ic_cur;
	logic          rsp_free;

	logic          qe_we;
	logic [IW-1:0] qe_waddr;
	logic [5:0]    qe_wdata;
	logic [IW-1:0] qe_raddr;

	scan_ctl_t     ctl;
	logic [IW-1:0] best_pos;
	logic [5:0]    best_vtx;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign dep_ok    = int'(req_q.depth) < MAX_VERTICES;
	assign dep_idx   = IW'(req_q.depth);
	assign full      = int'(count_q) >= MAX_VERTICES;
	assign issue     = (state_q == S_SCAN) && (idx_q < count_q);
	assign last_pos  = IW'(count_q - CW'(1));
	assign scan_done = v_s3 && (pos_s3 == last_pos);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// A recorded position that is out of range falls back to position 0.
	always_comb begin
		ri_pos = '0;
		if (dep_ok && (int'(pp_rd_q) < MAX_VERTICES)) begin
			ri_pos = IW'(pp_rd_q);
		end
	end

	assign np       = mpv_s2 ? mp_rd_q : 7'd0;
	assign elig     = ok_s2 && (np != 7'd0) && (int'(np) <= DEGREE_LIMIT);
	assign wt_raddr = WAW'(u_s2) * WAW'(DEGREE_LIMIT) + WAW'(np - 7'd1);
	assign ic_cur   = (dep_ok && ic_vld_q[dep_idx]) ? ic_rd_q : 7'd0;

	// Queue memory port selection.
	always_comb begin
		qe_we    = 1'b0;
		qe_waddr = '0;
		qe_wdata = req_q.vertex;
		qe_raddr = idx_q[IW-1:0];
		case (state_q)
			S_EXEC: begin
				if (req_q.req_type == REQ_INSERT && !full) begin
					qe_we    = 1'b1;
					qe_waddr = IW'(count_q);
				end
			end
			S_RD: begin
				qe_raddr = ri_pos;
			end
			S_RI1: begin
				qe_we    = 1'b1;
				qe_waddr = IW'(count_q);
				qe_wdata = qe_rd_q;
			end
			S_RI2: begin
				qe_we    = 1'b1;
				qe_waddr = pos_q;
			end
			S_TAIL: begin
				qe_raddr = last_pos;
				if (pop_step_q == 3'd1) begin
					qe_we    = 1'b1;
					qe_waddr = best_pos;
					qe_wdata = qe_rd_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (qe_we) begin
			qe_mem[qe_waddr] <= qe_wdata;
		end
		qe_rd_q <= qe_mem[qe_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TAIL && pop_step_q == 3'd1 && dep_ok) begin
			pp_mem[dep_idx] <= 6'(best_pos);
		end
		pp_rd_q <= pp_mem[dep_idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD && req_q.req_type == REQ_INC_CNT && dep_ok &&
		    ic_cur < INS_CNT_MAX) begin
			ic_mem[dep_idx] <= ic_cur + 7'd1;
		end
		ic_rd_q <= ic_mem[dep_idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && req_q.req_type == REQ_WR_PAR &&
		    int'(req_q.vertex) < MAX_VERTICES) begin
			mp_mem[IW'(req_q.vertex)] <= req_q.parent_count;
		end
		mp_rd_q <= mp_mem[IW'(qe_rd_q)];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && req_q.req_type == REQ_WR_WGT &&
		    int'(req_q.vertex) < MAX_VERTICES && int'(req_q.slot) < DEGREE_LIMIT) begin
			wt_mem[WAW'(req_q.vertex) * WAW'(DEGREE_LIMIT) + WAW'(req_q.slot)] <=
				req_q.weight;
		end
		wt_rd_q <= wt_mem[wt_raddr];
	end

	// Valid bits stand in for the zero reset of the count tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				ic_vld_q[i] <= 1'b0;
				mp_vld_q[i] <= 1'b0;
			end
		end else begin
			if (state_q == S_EXEC && req_q.req_type == REQ_CLEAR) begin
				for (int i = 0; i < MAX_VERTICES; i++) begin
					if (i < int'(req_q.vertex_count)) begin
						ic_vld_q[i] <= 1'b0;
					end
				end
			end
			if (state_q == S_EXEC && req_q.req_type == REQ_ZERO_CNT && dep_ok) begin
				ic_vld_q[dep_idx] <= 1'b0;
			end
			if (state_q == S_RD && req_q.req_type == REQ_INC_CNT && dep_ok &&
			    ic_cur < INS_CNT_MAX) begin
				ic_vld_q[dep_idx] <= 1'b1;
			end
			if (state_q == S_EXEC && req_q.req_type == REQ_WR_PAR &&
			    int'(req_q.vertex) < MAX_VERTICES) begin
				mp_vld_q[IW'(req_q.vertex)] <= 1'b1;
			end
		end
	end

	// Scan pipeline: queue read, parent-count read, weight read, compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1  <= idx_q[IW-1:0];
		pos_s2  <= pos_s1;
		u_s2    <= qe_rd_q;
		ok_s2   <= int'(qe_rd_q) < MAX_VERTICES;
		mpv_s2  <= mp_vld_q[IW'(qe_rd_q)];
		pos_s3  <= pos_s2;
		u_s3    <= u_s2;
		elig_s3 <= elig;
	end

	assign ctl.clear = (state_q == S_EXEC);
	assign ctl.take  = v_s3;
	assign ctl.first = (pos_s3 == '0);
	assign ctl.elig  = elig_s3;

	mwq_min_track #(
		.PW(IW)
	) u_min_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pos      (pos_s3),
		.vtx      (u_s3),
		.wgt      (wt_rd_q),
		.best_pos (best_pos),
		.best_vtx (best_vtx)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			pop_step_q <= '0;
			status_q   <= ST_OK;
			popped_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q  <= S_EXEC;
						status_q <= ST_OK;
						popped_q <= '0;
					end
				end
				S_EXEC: begin
					state_q <= S_FIN;
					case (req_q.req_type)
						REQ_INSERT: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						REQ_REINSERT: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								state_q <= S_RD;
							end
						end
						REQ_POP: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						REQ_REMOVE, REQ_INC_CNT: begin
							state_q <= S_RD;
						end
						REQ_CLEAR: begin
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_RD: begin
					if (req_q.req_type == REQ_REINSERT) begin
						state_q <= S_RI1;
					end else begin
						state_q <= S_FIN;
						if (req_q.req_type == REQ_REMOVE &&
						    int'(count_q) >= int'(ic_cur)) begin
							count_q <= count_q - CW'(ic_cur);
						end
					end
				end
				S_RI1: begin
					state_q <= S_RI2;
				end
				S_RI2: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FIN;
				end
				S_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (scan_done) begin
						pop_step_q <= '0;
						state_q    <= S_TAIL;
					end
				end
				S_TAIL: begin
					// Step 0 reads the tail entry, step 1 moves it into the hole.
					pop_step_q <= pop_step_q + 3'd1;
					if (pop_step_q == 3'd1) begin
						popped_q <= best_vtx;
						count_q  <= count_q - CW'(1);
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_RD) begin
			pos_q <= ri_pos;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FIN && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && rsp_free) begin
			rsp_q.popped_vertex <= popped_q;
			rsp_q.status        <= status_q;
			rsp_q.queue_count   <= 7'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Assertions.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_VERTICES)
		else $error("queue count above capacity");

	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q == S_SCAN))
		else $error("scan pipeline word outside of a pop scan");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("response raised without a finished request");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted request did not start");

endmodule

/* sim/tb_min_weight_extendable_queue_unit.sv */
`timescale 1ns / 1ps

module tb_min_weight_extendable_queue_unit;
	import mwq_pkg::*;

	localparam int MAX_VERTICES = 64;
	localparam int DEGREE_LIMIT = 8;
	localparam int REQ_CODE_MAX = 15;
	localparam int RANDOM_ITEMS = 540;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 100;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int cycle_count     = 0;
	int rsp_hold_cycles = 0;
	bit burst_mode      = 1'b0;

	// Mirror of the queue, the per-depth state and both tables, plus the words still owed.
	class vertex_queue_shadow;
		logic [5:0]  entries [MAX_VERTICES];
		int          entry_count;
		logic [5:0]  pop_position [MAX_VERTICES];
		bit          pos_known [MAX_VERTICES];
		logic [6:0]  ins_count [MAX_VERTICES];
		logic [30:0] weights [MAX_VERTICES * DEGREE_LIMIT];
		bit          weight_known [MAX_VERTICES * DEGREE_LIMIT];
		logic [6:0]  parents [MAX_VERTICES];
		rsp_t        expected_words [$];
		int          mismatch_count;

		function new();
			entry_count = 0;
			mismatch_count = 0;
			foreach (entries[i]) begin
				entries[i] = '0;
				pop_position[i] = '0;
				pos_known[i] = 1'b0;
				ins_count[i] = '0;
				parents[i] = '0;
			end
			foreach (weights[i]) begin
				weights[i] = '0;
				weight_known[i] = 1'b0;
			end
		endfunction

		function void apply_request(req_t r);
			rsp_t        word;
			int          d;
			int          pos;
			int          best_pos;
			int          v;
			int          np;
			int          n;
			int          idx;
			logic [30:0] best_w;
			bit          found;

			word = '0;
			word.status = ST_OK;
			d = int'(r.depth);
			case (r.req_type)
			REQ_INSERT: begin
				if (entry_count >= MAX_VERTICES) begin
					word.status = ST_FULL;
				end else begin
					entries[entry_count] = r.vertex;
					entry_count++;
				end
			end
			REQ_REINSERT: begin
				if (entry_count >= MAX_VERTICES) begin
					word.status = ST_FULL;
				end else begin
					pos = int'(pop_position[d]);
					entries[entry_count] = entries[pos];
					entry_count++;
					entries[pos] = r.vertex;
				end
			end
			REQ_POP: begin
				if (entry_count == 0) begin
					word.status = ST_EMPTY;
				end else begin
					// Strict less-than keeps the first position on ties; with nothing
					// eligible the search falls back to position 0.
					found = 1'b0;
					best_pos = 0;
					best_w = '0;
					for (int i = 0; i < entry_count; i++) begin
						v = int'(entries[i]);
						np = int'(parents[v]);
						if (np >= 1 && np <= DEGREE_LIMIT) begin
							idx = v * DEGREE_LIMIT + np - 1;
							if (!found || weights[idx] < best_w) begin
								found = 1'b1;
								best_w = weights[idx];
								best_pos = i;
							end
						end
					end
					word.popped_vertex = entries[best_pos];
					pop_position[d] = 6'(best_pos);
					pos_known[d] = 1'b1;
					entries[best_pos] = entries[entry_count - 1];
					entry_count--;
				end
			end
			REQ_REMOVE: begin
				n = int'(ins_count[d]);
				if (entry_count >= n)
					entry_count -= n;
			end
			REQ_CLEAR: begin
				for (int i = 0; i < r.vertex_count && i < MAX_VERTICES; i++)
					ins_count[i] = '0;
				entry_count = 0;
			end
			REQ_ZERO_CNT: ins_count[d] = '0;
			REQ_INC_CNT: begin
				if (ins_count[d] < INS_CNT_MAX)
					ins_count[d]++;
			end
			REQ_WR_WGT: begin
				if (r.slot < DEGREE_LIMIT) begin
					idx = int'(r.vertex) * DEGREE_LIMIT + int'(r.slot);
					weights[idx] = r.weight;
					weight_known[idx] = 1'b1;
				end
			end
			REQ_WR_PAR: parents[r.vertex] = r.parent_count;
			default: ;
			endcase
			word.queue_count = 7'(entry_count);
			expected_words.push_back(word);
		endfunction

		function void compare_response(rsp_t got);
			rsp_t want;

			if (expected_words.size() == 0) begin
				$display("%0t: response word with none expected: vertex %0d status %0d count %0d",
					$time, got.popped_vertex, got.status, got.queue_count);
				mismatch_count++;
				return;
			end
			want = expected_words.pop_front();
			if (got.popped_vertex !== want.popped_vertex) begin
				$display("%0t: popped_vertex expected %0d, got %0d",
					$time, want.popped_vertex, got.popped_vertex);
				mismatch_count++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
				mismatch_count++;
			end
			if (got.queue_count !== want.queue_count) begin
				$display("%0t: queue_count expected %0d, got %0d",
					$time, want.queue_count, got.queue_count);
				mismatch_count++;
			end
		endfunction
	endclass

	vertex_queue_shadow shadow;

	min_weight_extendable_queue_unit #(
		.MAX_VERTICES(MAX_VERTICES),
		.DEGREE_LIMIT(DEGREE_LIMIT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int sender_gap();
		int roll;

		roll = $urandom_range(99);
		if (roll < 40)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t make_request(input logic [3:0] code, input int v, input int d,
		input int s, input logic [30:0] w, input int pc, input int vc);
		req_t r;

		r.req_type = code;
		r.vertex = 6'(v);
		r.depth = 6'(d);
		r.slot = 3'(s);
		r.weight = w;
		r.parent_count = 7'(pc);
		r.vertex_count = 7'(vc);
		return r;
	endfunction

	function automatic logic [3:0] pick_code(input mix_t mode);
		int roll;

		roll = $urandom_range(99);
		case (mode)
		MIX_FILL: begin
			if (roll < 70) return REQ_INSERT;
			if (roll < 85) return REQ_REINSERT;
			if (roll < 90) return REQ_POP;
			if (roll < 95) return REQ_WR_WGT;
			return REQ_WR_PAR;
		end
		MIX_DRAIN: begin
			if (roll < 60) return REQ_POP;
			if (roll < 70) return REQ_INSERT;
			if (roll < 75) return REQ_REINSERT;
			if (roll < 85) return REQ_REMOVE;
			if (roll < 86) return REQ_CLEAR;
			if (roll < 87) return REQ_ZERO_CNT;
			if (roll < 91) return REQ_INC_CNT;
			if (roll < 95) return REQ_WR_WGT;
			return REQ_WR_PAR;
		end
		default: begin
			if (roll < 22) return REQ_INSERT;
			if (roll < 32) return REQ_REINSERT;
			if (roll < 52) return REQ_POP;
			if (roll < 58) return REQ_REMOVE;
			if (roll < 61) return REQ_CLEAR;
			if (roll < 65) return REQ_ZERO_CNT;
			if (roll < 75) return REQ_INC_CNT;
			if (roll < 85) return REQ_WR_WGT;
			if (roll < 97) return REQ_WR_PAR;
			return 4'($urandom_range(REQ_WR_PAR + 1, REQ_CODE_MAX));
		end
		endcase
	endfunction

	// Random contents, but a reinsert only uses a depth that a pop has recorded and a
	// parent count never points a queued vertex at a weight that was not loaded.
	function automatic req_t pick_request(input mix_t mode);
		req_t r;
		int   pc;
		int   roll;
		int   known [$];

		r = {$urandom(), $urandom()};
		r.req_type = pick_code(mode);
		if ($urandom_range(4) != 0)
			r.depth = 6'($urandom_range(7));
		if ($urandom_range(9) < 7)
			r.vertex = 6'($urandom_range(15));
		if ($urandom_range(1) == 1)
			r.weight = 31'($urandom_range(15));
		case (r.req_type)
		REQ_REINSERT: begin
			for (int d = 0; d < MAX_VERTICES; d++)
				if (shadow.pos_known[d])
					known.push_back(d);
			if (known.size() == 0)
				r.req_type = REQ_INSERT;
			else
				r.depth = 6'(known[$urandom_range(known.size() - 1)]);
		end
		REQ_WR_PAR: begin
			roll = $urandom_range(99);
			if (roll < 80)
				pc = $urandom_range(1, DEGREE_LIMIT);
			else if (roll < 90)
				pc = 0;
			else
				pc = $urandom_range(127);
			r.parent_count = 7'(pc);
			if (pc >= 1 && pc <= DEGREE_LIMIT &&
				!shadow.weight_known[int'(r.vertex) * DEGREE_LIMIT + pc - 1]) begin
				r.req_type = REQ_WR_WGT;
				r.slot = 3'(pc - 1);
			end
		end
		REQ_CLEAR: begin
			if ($urandom_range(1) == 1)
				r.vertex_count = 7'($urandom_range(MAX_VERTICES));
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(input req_t word);
		int gap;

		gap = burst_mode ? 0 : sender_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= word;
		do @(posedge clk); while (req_stall);
		shadow.apply_request(word);
	endtask

	task automatic wait_for_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (shadow.expected_words.size() != 0);
	endtask

	// Response side: random stall runs, plus a long hold-off when the stimulus asks for one.
	initial begin
		int run_left;
		int roll;
		bit stall_now;

		run_left = 0;
		stall_now = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				shadow.compare_response(rsp);
			if (rsp_hold_cycles > 0) begin
				stall_now = 1'b1;
				run_left = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else if (run_left <= 0) begin
				roll = $urandom_range(99);
				if (roll < 45) begin
					stall_now = 1'b0;
					run_left = $urandom_range(1, 20);
				end else if (roll < 85) begin
					stall_now = 1'b1;
					run_left = $urandom_range(1, 3);
				end else if (roll < 97) begin
					stall_now = 1'b1;
					run_left = $urandom_range(4, 20);
				end else begin
					stall_now = 1'b1;
					run_left = $urandom_range(30, 100);
				end
			end
			rsp_stall <= stall_now;
			run_left--;
		end
	end

	initial begin
		int   random_sent;
		int   seg;
		int   seg_len;
		mix_t mode;

		shadow = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(REQ_POP, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_WR_WGT, 5, 0, 0, 31'h7FFF_FFFF, 0, 0));
		send_request(make_request(REQ_WR_WGT, 9, 0, 7, 0, 0, 0));
		send_request(make_request(REQ_WR_WGT, 63, 0, 2, 100, 0, 0));
		send_request(make_request(REQ_WR_WGT, 0, 0, 0, 100, 0, 0));
		send_request(make_request(REQ_WR_PAR, 5, 0, 0, 0, 1, 0));
		send_request(make_request(REQ_WR_PAR, 9, 0, 0, 0, DEGREE_LIMIT, 0));
		send_request(make_request(REQ_WR_PAR, 63, 0, 0, 0, 3, 0));
		send_request(make_request(REQ_WR_PAR, 0, 0, 0, 0, 1, 0));
		send_request(make_request(REQ_INSERT, 12, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_INSERT, 63, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_INSERT, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_INSERT, 9, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_INSERT, 5, 0, 0, 0, 0, 0));
		// Vertex 9 has weight zero; then vertices 63 and 0 tie and the earlier one wins.
		send_request(make_request(REQ_POP, 0, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_POP, 0, 63, 0, 0, 0, 0));
		send_request(make_request(REQ_REINSERT, 63, 63, 0, 0, 0, 0));
		send_request(make_request(REQ_WR_PAR, 9, 0, 0, 0, 64, 0));
		send_request(make_request(REQ_WR_PAR, 5, 0, 0, 0, 127, 0));
		send_request(make_request(REQ_INC_CNT, 0, 3, 0, 0, 0, 0));
		send_request(make_request(REQ_INC_CNT, 0, 3, 0, 0, 0, 0));
		send_request(make_request(REQ_REMOVE, 0, 3, 0, 0, 0, 0));
		send_request(make_request(REQ_ZERO_CNT, 0, 3, 0, 0, 0, 0));
		send_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 127));
		// Neither queued vertex has a mapped parent, so the pop falls back to the head.
		send_request(make_request(REQ_INSERT, 40, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_INSERT, 12, 0, 0, 0, 0, 0));
		send_request(make_request(REQ_POP, 0, 2, 0, 0, 0, 0));
		send_request(make_request(REQ_INC_CNT, 0, 63, 0, 0, 0, 0));
		send_request(make_request(REQ_INC_CNT, 0, 63, 0, 0, 0, 0));
		send_request(make_request(REQ_REMOVE, 0, 63, 0, 0, 0, 0));
		send_request(make_request(4'(REQ_CODE_MAX), 63, 63, 7, 31'h7FFF_FFFF, 127, 127));

		random_sent = 0;
		seg = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (seg == 1)
				mode = MIX_FILL;
			else if (seg == 2)
				mode = MIX_DRAIN;
			else
				mode = mix_t'($urandom_range(2));
			seg_len = (mode == MIX_BALANCED) ? 60 : 100;
			burst_mode = ($urandom_range(3) == 0);
			if (seg == 3) begin
				// Push one inserted count past its saturation point.
				for (int k = 0; k < 130; k++)
					send_request(make_request(REQ_INC_CNT, 0, 5, 0, 0, 0, 0));
				send_request(make_request(REQ_REMOVE, 0, 5, 0, 0, 0, 0));
				send_request(make_request(REQ_ZERO_CNT, 0, 5, 0, 0, 0, 0));
			end
			if (seg == 4) begin
				rsp_hold_cycles = HOLD_CYCLES;
				burst_mode = 1'b1;
			end
			for (int k = 0; k < seg_len; k++)
				send_request(pick_request(mode));
			random_sent += seg_len;
			if (seg == 5 || $urandom_range(3) == 0)
				wait_for_responses();
			seg++;
		end

		wait_for_responses();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
